>>> rtl/trq_pkg.sv
package trq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;

  // Widths of the channel fields.
  localparam int KIND_W = 3;
  localparam int TID_W  = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Only the low bits of the 16-bit id field that the slots can hold are kept.
  localparam int KEY_W = (ID_BITS < TID_W) ? ID_BITS : TID_W;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    K_PUSH   = 3'd0,
    K_POP    = 3'd1,
    K_PEEK   = 3'd2,
    K_FIND   = 3'd3,
    K_REMOVE = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // Controls broadcast from the sequencer to every slot cell.
  typedef struct packed {
    logic             start;  // new item taken: seed the scan token at the head
    logic             adv;    // move the scan token one cell toward the tail
    logic             stop;   // item finished: drop the scan token
    logic             shift;  // close the gap: cells not yet passed take the right id
    logic [KEY_W-1:0] key;    // id under search, or id to append
  } cell_ctl_t;

endpackage

>>> rtl/trq_req_if.sv
interface trq_req_if import trq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink (input valid, input kind, input thread_id, output ready);
endinterface

>>> rtl/trq_rsp_if.sv
interface trq_rsp_if import trq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TID_W-1:0]  result_id;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output result_id, output status, output occupancy,
                  input ready);
  modport sink (input valid, input result_id, input status, input occupancy,
                output ready);
endinterface

>>> rtl/trq_cell.sv
module trq_cell import trq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic             occ_i,
  input  logic             load_i,
  input  logic             tok_i,
  input  logic [KEY_W-1:0] right_id_i,
  output logic             tok_o,
  output logic [KEY_W-1:0] id_o,
  output logic             hit_o
);

  logic             tok_q, tok_d;
  logic             passed_q, passed_d;
  logic [KEY_W-1:0] id_q, id_d;

  // The scan token enters at the head and walks one cell per step.
  always_comb begin
    tok_d = tok_q;
    if (ctl_i.stop) begin
      tok_d = 1'b0;
    end else if (ctl_i.start || ctl_i.adv) begin
      tok_d = tok_i;
    end
  end

  // A cell is marked once the token has left it; such cells hold on a removal.
  always_comb begin
    passed_d = passed_q;
    if (ctl_i.start) begin
      passed_d = 1'b0;
    end else if (ctl_i.adv) begin
      passed_d = passed_q | tok_q;
    end
  end

  // Slot contents: append at the tail or take the neighbor's id to close a gap.
  always_comb begin
    id_d = id_q;
    if (load_i) begin
      id_d = ctl_i.key;
    end else if (ctl_i.shift && !passed_q) begin
      id_d = right_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      passed_q <= 1'b0;
    end else begin
      tok_q    <= tok_d;
      passed_q <= passed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign tok_o = tok_q;
  assign id_o  = id_q;
  assign hit_o = tok_q & occ_i & (id_q == ctl_i.key);

endmodule

>>> rtl/trq_chain.sv
module trq_chain import trq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctl_t              ctl_i,
  input  logic [QUEUE_DEPTH-1:0] occ_i,
  input  logic [QUEUE_DEPTH-1:0] load_i,
  output logic [KEY_W-1:0]       head_id_o,
  output logic                   hit_o
);

  logic [QUEUE_DEPTH-1:0] tok;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [KEY_W-1:0]       ids [QUEUE_DEPTH];

  // Slot 0 is the head; each cell passes its token right and takes ids from the right.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             tok_in;
    logic [KEY_W-1:0] right_id;

    if (i == 0) begin : g_head
      assign tok_in = ctl_i.start;
    end else begin : g_body
      assign tok_in = tok[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_id = ids[i];
    end else begin : g_mid
      assign right_id = ids[i+1];
    end

    trq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .occ_i      (occ_i[i]),
      .load_i     (load_i[i]),
      .tok_i      (tok_in),
      .right_id_i (right_id),
      .tok_o      (tok[i]),
      .id_o       (ids[i]),
      .hit_o      (hit[i])
    );
  end

  // At most one cell holds the token, so a plain OR finds the match.
  assign hit_o     = |hit;
  assign head_id_o = ids[0];

endmodule

>>> rtl/thread_ready_queue_top.sv
// Ordered ready queue of up to QUEUE_DEPTH thread ids, held as a row of slot
// cells with the head in slot 0. One request is taken at a time. Push, pop,
// peek and unknown kinds finish in the run state once the output register is
// free. Find and remove walk a token from the head toward the tail, one slot
// per cycle while the output register is free, and finish when the token
// meets the first matching id or the last held id. A removal closes the gap
// behind the match. The result waits in an output register; while it is not
// taken, a finished item holds the block.
module thread_ready_queue_top import trq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  trq_req_if.sink   req,
  trq_rsp_if.source rsp
);

  state_e           state_q, state_d;
  kind_e            kind_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] scan_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic              rsp_valid_q;
  logic [TID_W-1:0]  rid_q;
  logic [STAT_W-1:0] stat_q;
  logic [OCC_W-1:0]  occ_q;

  logic                   accept;
  logic                   out_free;
  logic                   done;
  logic                   shift;
  logic                   push_en;
  status_e                res_stat;
  logic [KEY_W-1:0]       res_id;
  logic [KEY_W-1:0]       head_id;
  logic                   hit_any;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] load;
  cell_ctl_t              ctl;

  assign accept   = req.valid & req.ready;
  assign out_free = !rsp_valid_q | rsp.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    req.ready = 1'b0;
    case (state_q)
      S_IDLE:  req.ready = 1'b1;
      S_RUN:   req.ready = 1'b0;
      default: req.ready = 1'b0;
    endcase
  end

  // Operation decode: decide the result and the change to the queue.
  always_comb begin
    done     = 1'b0;
    shift    = 1'b0;
    push_en  = 1'b0;
    res_stat = ST_OK;
    res_id   = '0;
    count_d  = count_q;
    if (state_q == S_RUN && out_free) begin
      case (kind_q)
        K_PUSH: begin
          done = 1'b1;
          if (count_q == CNT_W'(QUEUE_DEPTH)) begin
            res_stat = ST_FULL;
          end else begin
            push_en = 1'b1;
            count_d = count_q + 1'b1;
            res_id  = key_q;
          end
        end
        K_POP, K_PEEK: begin
          done = 1'b1;
          if (count_q == '0) begin
            res_stat = ST_EMPTY;
          end else begin
            res_id = head_id;
            if (kind_q == K_POP) begin
              shift   = 1'b1;
              count_d = count_q - 1'b1;
            end
          end
        end
        K_FIND, K_REMOVE: begin
          if (count_q == '0) begin
            done     = 1'b1;
            res_stat = ST_EMPTY;
          end else if (hit_any) begin
            done   = 1'b1;
            res_id = key_q;
            if (kind_q == K_REMOVE) begin
              shift   = 1'b1;
              count_d = count_q - 1'b1;
            end
          end else if (CNT_W'(scan_q) + 1'b1 == count_q) begin
            done     = 1'b1;
            res_stat = ST_NOT_FOUND;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  // Cell controls and per-slot occupancy and append select.
  always_comb begin
    ctl.start = accept;
    ctl.adv   = (state_q == S_RUN) && out_free && !done;
    ctl.stop  = done;
    ctl.shift = shift;
    ctl.key   = key_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i]  = CNT_W'(i) < count_q;
      load[i] = push_en && (count_q == CNT_W'(i));
    end
  end

  trq_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .occ_i     (occ),
    .load_i    (load),
    .head_id_o (head_id),
    .hit_o     (hit_any)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (accept) begin
        scan_q <= '0;
      end else if (ctl.adv) begin
        scan_q <= scan_q + 1'b1;
      end
      if (done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(req.kind);
      key_q  <= req.thread_id[KEY_W-1:0];
    end
    if (done) begin
      rid_q  <= TID_W'(res_id);
      stat_q <= res_stat;
      occ_q  <= OCC_W'(count_d);
    end
  end

  assign rsp.valid     = rsp_valid_q;
  assign rsp.result_id = rid_q;
  assign rsp.status    = stat_q;
  assign rsp.occupancy = occ_q;

endmodule

>>> verif/trq_tb_pkg.sv
package trq_tb_pkg;
  import trq_pkg::*;

  // One expected result item, at the widths of the response channel.
  typedef struct packed {
    logic [TID_W-1:0] result_id;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  // Mirror of the ready queue: it tracks the held ids in order, head first,
  // and keeps the result each accepted request is due to produce.
  class ready_queue_scoreboard;
    logic [KEY_W-1:0] held_ids[QUEUE_DEPTH];
    int               held_count;
    queue_result_t    due_results[$];
    int               errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Apply one accepted request to the mirror and queue its result.
    function void take_request(input logic [KIND_W-1:0] kind,
                               input logic [TID_W-1:0] tid);
      queue_result_t    res;
      logic [KEY_W-1:0] key;
      int               pos;
      key           = tid[KEY_W-1:0];
      res.result_id = '0;
      res.status    = ST_OK;
      case (kind)
        K_PUSH: begin
          if (held_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            held_ids[held_count] = key;
            held_count++;
            res.result_id = TID_W'(key);
          end
        end
        K_POP, K_PEEK, K_FIND, K_REMOVE: begin
          if (held_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            // Pop and peek act on the head; find and remove scan from it.
            pos = 0;
            if (kind == K_FIND || kind == K_REMOVE) begin
              while (pos < held_count && held_ids[pos] != key) pos++;
            end
            if (pos >= held_count) begin
              res.status = ST_NOT_FOUND;
            end else begin
              res.result_id = TID_W'(held_ids[pos]);
              if (kind == K_POP || kind == K_REMOVE) begin
                for (int i = pos; i < held_count - 1; i++) held_ids[i] = held_ids[i + 1];
                held_count--;
              end
            end
          end
        end
        default: begin
          // Unused kinds leave the queue alone and report ok.
        end
      endcase
      res.occupancy = OCC_W'(held_count);
      due_results.push_back(res);
    endfunction

    function void flag_field(input string what, input longint unsigned now,
                             input logic [31:0] exp_val, input logic [31:0] got_val);
      errors++;
      $display("t=%0d ns: %s mismatch, expected %0h, got %0h", now, what, exp_val, got_val);
    endfunction

    // Compare one result item from the block with the oldest expectation.
    function void match_result(input logic [TID_W-1:0] rid,
                               input logic [STAT_W-1:0] stat,
                               input logic [OCC_W-1:0] occ,
                               input longint unsigned now);
      queue_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("t=%0d ns: unexpected result, expected none, got id %0h status %0d occ %0d",
                 now, rid, stat, occ);
        return;
      end
      want = due_results.pop_front();
      if (rid !== want.result_id) begin
        flag_field("result_id", now, 32'(want.result_id), 32'(rid));
      end
      if (stat !== want.status) begin
        flag_field("status", now, 32'(want.status), 32'(stat));
      end
      if (occ !== want.occupancy) begin
        flag_field("occupancy", now, 32'(want.occupancy), 32'(occ));
      end
    endfunction

    // Anything still waiting at the end never came out of the block.
    function void flag_leftovers(input longint unsigned now);
      if (due_results.size() != 0) begin
        errors++;
        $display("t=%0d ns: missing results, expected 0 pending, got %0d",
                 now, due_results.size());
      end
    endfunction
  endclass

endpackage

>>> verif/tb.sv
module tb;
  import trq_pkg::*;
  import trq_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNUSED_KIND_LO = int'(K_REMOVE) + 1;
  localparam int UNUSED_KIND_HI = (1 << KIND_W) - 1;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_ITEMS    = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  trq_req_if req_bus ();
  trq_rsp_if rsp_bus ();

  thread_ready_queue_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_bus),
    .rsp    (rsp_bus)
  );

  ready_queue_scoreboard sb;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Response side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every response item taken is checked against the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      sb.match_result(rsp_bus.result_id, rsp_bus.status, rsp_bus.occupancy, $time);
    end
  end

  // Offer one request item, with random idle cycles ahead of it, and wait
  // until it is accepted. Called and returns at a falling edge.
  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.kind      <= kind;
    req_bus.thread_id <= tid;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    sb.take_request(kind, tid);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  tid;
    logic [TID_W-1:0]  tail_id;
    int                roll;
    bit                fill_mode;

    sb                = new();
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.kind      = K_PUSH;
    req_bus.thread_id = '0;
    rsp_bus.ready     = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_req          = 1'b0;
    hold_left         = 0;
    cycle_count       = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every read-type operation and the lowest and highest unused kinds on an empty queue.
    send_req(K_POP, '0);
    send_req(K_PEEK, '1);
    send_req(K_FIND, 16'h1234);
    send_req(K_REMOVE, 16'h1234);
    send_req(KIND_W'(UNUSED_KIND_LO), 16'hFFFF);
    send_req(KIND_W'(UNUSED_KIND_HI), 16'h0000);

    // Fill to the brim with the extreme ids and some duplicates.
    tail_id = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0) tail_id = '0;
      else if (i == 1) tail_id = '1;
      else if (i % 4 == 2) tail_id = 16'h00A5;
      else tail_id = TID_W'(i * 16'h1111 + 16'h0101);
      send_req(K_PUSH, tail_id);
    end

    // Full queue, longest scans, removal from the middle and the tail.
    send_req(K_PUSH, 16'h7777);
    send_req(KIND_W'(UNUSED_KIND_HI), 16'h5A5A);
    send_req(K_FIND, tail_id);
    send_req(K_FIND, 16'hBEEF);
    send_req(K_REMOVE, 16'h00A5);
    send_req(K_REMOVE, tail_id);
    send_req(K_PEEK, '0);
    send_req(K_POP, '0);
    drain_results();

    // Random traffic in four idling phases, with fill and drain bursts.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        if (phase == 2 && n == 150) drain_results();
        fill_mode = ((n / 40) % 2 == 0);
        roll      = $urandom_range(99);
        if (fill_mode) begin
          if (roll < 55) kind = K_PUSH;
          else if (roll < 65) kind = K_POP;
          else if (roll < 70) kind = K_PEEK;
          else if (roll < 80) kind = K_FIND;
          else if (roll < 97) kind = K_REMOVE;
          else kind = KIND_W'($urandom_range(UNUSED_KIND_HI, UNUSED_KIND_LO));
        end else begin
          if (roll < 20) kind = K_PUSH;
          else if (roll < 50) kind = K_POP;
          else if (roll < 58) kind = K_PEEK;
          else if (roll < 70) kind = K_FIND;
          else if (roll < 97) kind = K_REMOVE;
          else kind = KIND_W'($urandom_range(UNUSED_KIND_HI, UNUSED_KIND_LO));
        end

        // Ids: mostly held ones for lookups, a small pool for duplicates,
        // and fully random values so every bit toggles.
        roll = $urandom_range(99);
        if ((kind == K_FIND || kind == K_REMOVE) && sb.held_count > 0 && roll < 65) begin
          tid = TID_W'(sb.held_ids[$urandom_range(sb.held_count - 1)]);
        end else if (roll < 85) begin
          tid = TID_W'($urandom_range(7)) ^ 16'hA5C0;
        end else if (roll < 88) begin
          tid = '0;
        end else if (roll < 91) begin
          tid = '1;
        end else begin
          tid = TID_W'($urandom);
        end
        send_req(kind, tid);
      end
      drain_results();
    end

    // Let any straggling result show up before the verdict.
    repeat (QUEUE_DEPTH + 8) @(negedge clk_i);
    sb.flag_leftovers($time);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/trq_pkg.sv
rtl/trq_req_if.sv
rtl/trq_rsp_if.sv
rtl/trq_cell.sv
rtl/trq_chain.sv
rtl/thread_ready_queue_top.sv
verif/trq_tb_pkg.sv
verif/tb.sv
